[hdl/lps_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lps_pkg;

   // coordinate width of every endpoint and pixel field
   localparam int COORD_BITS = 12;
   localparam int COLOR_BITS = 32;

   // request kinds
   typedef enum logic [0:0] {
      REQ_START = 1'b0,
      REQ_STEP  = 1'b1
   } req_kind_type;

   // line modes
   typedef enum logic [1:0] {
      MODE_VERT    = 2'd0,
      MODE_STEEP   = 2'd1,
      MODE_SHALLOW = 2'd2
   } mode_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_REJECT = 2'd1,
      ST_IDLE   = 2'd2
   } status_type;

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      req_kind_type          req_type;
      coord_type             x_start;
      coord_type             y_start;
      coord_type             x_end;
      coord_type             y_end;
      logic [COLOR_BITS-1:0] color;
   } request_type;

   typedef struct packed {
      logic                  pixel_valid;
      coord_type             pixel_x;
      coord_type             pixel_y;
      logic [COLOR_BITS-1:0] pixel_color;
      logic                  last_pixel;
      status_type            status;
   } response_type;

   // decoded line setup handed from the setup logic to the stepper
   typedef struct packed {
      logic                   reject;
      mode_type               mode;
      coord_type              drive_pos;
      coord_type              drive_end;
      coord_type              minor_pos;
      coord_type              major_delta;
      logic signed [COORD_BITS:0] minor_delta;
   } setup_type;

endpackage

`default_nettype wire

[hdl/line_pixel_stepper.sv]
`timescale 1ns / 1ps
`default_nettype none

// Incremental line rasteriser.
// req channel: a start request loads two endpoints and a colour; each step
// request then yields one pixel of the line, from the first point plus one
// up to the end point, with last_pixel set on the end point.
// rsp channel: exactly one response per request, in request order. Starts
// and steps with no line carry no pixel and report their status.
// A request reaches the response register at the clock edge after its
// transfer when the response side is free (input register, then response
// register).
// Throughput: one request per cycle sustained while rsp_ready stays high, set
// by the add and compare on the remainder term between the two registers.
// Reset clears the line state and empties both pipeline registers; no line is
// active afterwards. When the receiver stalls, the response holds in its
// register, one further request waits in the input register, and req_ready
// drops.
module line_pixel_stepper (
   input  var logic                  clock,
   input  var logic                  reset,
   input  var logic                  req_valid,
   output var logic                  req_ready,
   input  var lps_pkg::request_type  req_data,
   output var logic                  rsp_valid,
   input  var logic                  rsp_ready,
   output lps_pkg::response_type     rsp_data
);

   logic                  in_valid_ff;
   lps_pkg::request_type  in_item_ff;
   logic                  out_valid_ff;
   lps_pkg::response_type out_item_ff;
   lps_pkg::response_type result;
   logic                  advance;

   // the item in the input register moves on when the response slot frees
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   lps_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_item_ff),
      .result (result)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_item_ff <= req_data;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

endmodule

`default_nettype wire

[hdl/lps_setup.sv]
`timescale 1ns / 1ps
`default_nettype none

module lps_setup (
   input  var lps_pkg::request_type item,
   output lps_pkg::setup_type       setup
);

   localparam int CB = lps_pkg::COORD_BITS;

   logic signed [CB:0] dx;
   logic signed [CB:0] dy;
   logic signed [CB:0] dx_neg;
   logic signed [CB:0] dy_neg;
   logic [CB-1:0]      adx;
   logic [CB-1:0]      ady;
   logic               vertical;
   logic               steep;
   logic signed [CB:0] major;

   // signed deltas and their magnitudes
   assign dx     = $signed({1'b0, item.x_end}) - $signed({1'b0, item.x_start});
   assign dy     = $signed({1'b0, item.y_end}) - $signed({1'b0, item.y_start});
   assign dx_neg = -dx;
   assign dy_neg = -dy;
   assign adx    = dx[CB] ? dx_neg[CB-1:0] : dx[CB-1:0];
   assign ady    = dy[CB] ? dy_neg[CB-1:0] : dy[CB-1:0];

   // mode pick and driving delta
   assign vertical = (dx == '0);
   assign steep    = (ady > adx);
   assign major    = (vertical || steep) ? dy : dx;

   always_comb begin
      setup.reject      = major[CB] || (major == '0);
      setup.major_delta = major[CB-1:0];
      if (vertical) begin
         setup.mode = lps_pkg::MODE_VERT;
      end else if (steep) begin
         setup.mode = lps_pkg::MODE_STEEP;
      end else begin
         setup.mode = lps_pkg::MODE_SHALLOW;
      end
      // shallow lines are driven along x, the rest along y
      if (!vertical && !steep) begin
         setup.drive_pos   = item.x_start;
         setup.drive_end   = item.x_end;
         setup.minor_pos   = item.y_start;
         setup.minor_delta = dy;
      end else begin
         setup.drive_pos   = item.y_start;
         setup.drive_end   = item.y_end;
         setup.minor_pos   = item.x_start;
         setup.minor_delta = dx;
      end
   end

endmodule

`default_nettype wire

[hdl/lps_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module lps_core (
   input  var logic                  clock,
   input  var logic                  reset,
   input  var logic                  fire,
   input  var lps_pkg::request_type  item,
   output lps_pkg::response_type     result
);

   localparam int CB = lps_pkg::COORD_BITS;
   localparam int SW = CB + 2;

   lps_pkg::setup_type setup;

   logic                           line_active_ff;
   lps_pkg::mode_type              line_mode_ff;
   logic [CB-1:0]                  drive_pos_ff;
   logic [CB-1:0]                  drive_end_ff;
   logic [CB-1:0]                  minor_pos_ff;
   logic [CB-1:0]                  remainder_acc_ff;
   logic [CB-1:0]                  major_delta_ff;
   logic signed [CB:0]             minor_delta_ff;
   logic [lps_pkg::COLOR_BITS-1:0] line_color_ff;

   logic [CB-1:0]      drive_pos_in;
   logic [CB-1:0]      minor_pos_in;
   logic [CB-1:0]      remainder_acc_in;
   logic signed [SW-1:0] sum;
   logic signed [SW-1:0] major_ext;
   logic signed [SW-1:0] sum_sub;
   logic signed [SW-1:0] sum_add;
   logic               last;
   logic               is_start;

   lps_setup u_setup (
      .item  (item),
      .setup (setup)
   );

   assign is_start = (item.req_type == lps_pkg::REQ_START);

   // one pixel step: advance the driving coordinate, fold the remainder
   assign drive_pos_in = drive_pos_ff + 1'b1;
   assign major_ext    = $signed({2'b00, major_delta_ff});
   assign sum          = $signed({2'b00, remainder_acc_ff})
                       + $signed({minor_delta_ff[CB], minor_delta_ff});
   assign sum_sub      = sum - major_ext;
   assign sum_add      = sum + major_ext;

   always_comb begin
      if (sum >= major_ext) begin
         remainder_acc_in = sum_sub[CB-1:0];
         minor_pos_in     = minor_pos_ff + 1'b1;
      end else if (sum[SW-1]) begin
         remainder_acc_in = sum_add[CB-1:0];
         minor_pos_in     = minor_pos_ff - 1'b1;
      end else begin
         remainder_acc_in = sum[CB-1:0];
         minor_pos_in     = minor_pos_ff;
      end
   end

   assign last = (drive_pos_in == drive_end_ff);

   // line state
   always_ff @(posedge clock) begin
      if (reset) begin
         line_active_ff   <= 1'b0;
         line_mode_ff     <= lps_pkg::MODE_VERT;
         drive_pos_ff     <= '0;
         drive_end_ff     <= '0;
         minor_pos_ff     <= '0;
         remainder_acc_ff <= '0;
         major_delta_ff   <= '0;
         minor_delta_ff   <= '0;
         line_color_ff    <= '0;
      end else if (fire) begin
         if (is_start) begin
            if (setup.reject) begin
               line_active_ff <= 1'b0;
            end else begin
               line_active_ff   <= 1'b1;
               line_mode_ff     <= setup.mode;
               drive_pos_ff     <= setup.drive_pos;
               drive_end_ff     <= setup.drive_end;
               minor_pos_ff     <= setup.minor_pos;
               remainder_acc_ff <= '0;
               major_delta_ff   <= setup.major_delta;
               minor_delta_ff   <= setup.minor_delta;
               line_color_ff    <= item.color;
            end
         end else if (line_active_ff) begin
            drive_pos_ff     <= drive_pos_in;
            minor_pos_ff     <= minor_pos_in;
            remainder_acc_ff <= remainder_acc_in;
            if (last) begin
               line_active_ff <= 1'b0;
            end
         end
      end
   end

   // result for the item in hand
   always_comb begin
      result = '0;
      if (is_start) begin
         result.status = setup.reject ? lps_pkg::ST_REJECT : lps_pkg::ST_OK;
      end else if (!line_active_ff) begin
         result.status = lps_pkg::ST_IDLE;
      end else begin
         result.pixel_valid = 1'b1;
         result.pixel_color = line_color_ff;
         result.last_pixel  = last;
         result.status      = lps_pkg::ST_OK;
         if (line_mode_ff == lps_pkg::MODE_SHALLOW) begin
            result.pixel_x = drive_pos_in;
            result.pixel_y = minor_pos_in;
         end else begin
            result.pixel_x = minor_pos_in;
            result.pixel_y = drive_pos_in;
         end
      end
   end

endmodule

`default_nettype wire

[hdl/lps_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module lps_checker (
   input var logic                  clock,
   input var logic                  reset,
   input var logic                  req_ready,
   input var logic                  rsp_valid,
   input var logic                  rsp_ready,
   input var lps_pkg::response_type rsp_data
);

   // pipeline empty straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("pipeline not empty after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

   // with the response slot empty, the input side never blocks
   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked with empty response slot");

   // a last pixel is a real pixel of an accepted line
   a_last_is_pixel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last_pixel) |->
         (rsp_data.pixel_valid && (rsp_data.status == lps_pkg::ST_OK)))
      else $error("last pixel flag on a response without a pixel");

endmodule

bind line_pixel_stepper lps_checker u_lps_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
